// ===== rtl/core/dip_pkg.sv =====
`default_nettype none
package dip_pkg;
  localparam int unsigned MaxBlockDef = 32;
  localparam logic [1:0] OpLoadAbove = 2'd0;
  localparam logic [1:0] OpLoadLeft  = 2'd1;
  localparam logic [1:0] OpEmitRow   = 2'd2;
  localparam logic [2:0] ModeD207 = 3'd0;
  localparam logic [2:0] ModeD63  = 3'd1;
  localparam logic [2:0] ModeD45  = 3'd2;
  localparam logic [2:0] ModeD117 = 3'd3;
  localparam logic [2:0] ModeD135 = 3'd4;
  localparam logic [2:0] ModeD153 = 3'd5;
  localparam logic [0:0] RegBlockLog2 = 1'd0;
  localparam logic [0:0] RegPredMode  = 1'd1;

  // tap selection for one pixel: signed unified edge positions, filter kind
  typedef struct packed {
    logic signed [8:0] j0;
    logic signed [8:0] j1;
    logic signed [8:0] j2;
    logic              avg3;
    logic              copy;
    logic              zero;
  } tap_sel_t;
endpackage
`default_nettype wire

// ===== rtl/core/dip_tap_gen.sv =====
`default_nettype none
// Per-pixel tap address generator: maps (mode, size, row, col) to edge positions.
// Positions use the unified edge: j >= 0 is above store entry j, j < 0 is left[-1-j].
module dip_tap_gen import dip_pkg::*; (
  input  wire logic [2:0] mode_i,
  input  wire logic [6:0] bs_i,
  input  wire logic [5:0] row_i,
  input  wire logic [5:0] col_i,
  output tap_sel_t        sel_o
);
  logic signed [8:0] r, c, bs, i, k, rr, cc, ab;
  always_comb begin
    r  = {3'b0, row_i};
    c  = {3'b0, col_i};
    bs = {2'b0, bs_i};
    sel_o = '0;
    i = '0; k = '0; rr = '0; cc = '0; ab = '0;
    case (mode_i)
      ModeD207: begin
        i = r + (c >>> 1);
        // left[x] is j = -1-x
        if (!c[0]) begin
          if (i < bs - 9'sd1) begin
            sel_o.j0 = -9'sd1 - i; sel_o.j1 = -9'sd2 - i;
          end else begin
            sel_o.copy = 1'b1; sel_o.j1 = -bs;
          end
        end else if (i < bs - 9'sd2) begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = -9'sd1 - i; sel_o.j1 = -9'sd2 - i; sel_o.j2 = -9'sd3 - i;
        end else if (i == bs - 9'sd2) begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = 9'sd1 - bs; sel_o.j1 = -bs; sel_o.j2 = -bs;
        end else begin
          sel_o.copy = 1'b1; sel_o.j1 = -bs;
        end
      end
      ModeD63: begin
        i = r >>> 1;
        if (r >= 9'sd2 && c >= bs - 9'sd1 - i) begin
          sel_o.copy = 1'b1; sel_o.j1 = bs;
        end else begin
          k = c + i;
          sel_o.avg3 = r[0];
          sel_o.j0 = k + 9'sd1; sel_o.j1 = k + 9'sd2; sel_o.j2 = k + 9'sd3;
        end
      end
      ModeD45: begin
        k = r + c;
        if (k < bs - 9'sd1) begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = k + 9'sd1; sel_o.j1 = k + 9'sd2; sel_o.j2 = k + 9'sd3;
        end else begin
          sel_o.copy = 1'b1; sel_o.j1 = bs;
        end
      end
      ModeD117: begin
        k  = ((r >>> 1) < c) ? (r >>> 1) : c;
        rr = r - (k <<< 1);
        cc = c - k;
        if (rr == 9'sd0) begin
          sel_o.j0 = cc; sel_o.j1 = cc + 9'sd1;
        end else if (rr == 9'sd1) begin
          sel_o.avg3 = 1'b1;
          if (cc == 9'sd0) begin
            sel_o.j0 = -9'sd1; sel_o.j1 = 9'sd0; sel_o.j2 = 9'sd1;
          end else begin
            sel_o.j0 = cc - 9'sd1; sel_o.j1 = cc; sel_o.j2 = cc + 9'sd1;
          end
        end else if (rr == 9'sd2) begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = 9'sd0; sel_o.j1 = -9'sd1; sel_o.j2 = -9'sd2;
        end else begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = 9'sd2 - rr; sel_o.j1 = 9'sd1 - rr; sel_o.j2 = -rr;
        end
      end
      ModeD135: begin
        k = c - r;
        sel_o.avg3 = 1'b1;
        sel_o.j0 = k - 9'sd1; sel_o.j1 = k; sel_o.j2 = k + 9'sd1;
      end
      ModeD153: begin
        // steps back diagonally: subtract min(r, c/2) once
        ab = ((c >>> 1) < r) ? (c >>> 1) : r;
        if (c[0] == 1'b0 && (c >>> 1) <= r) begin
          rr = r - (c >>> 1); cc = 9'sd0;
        end else if (c[0] && (c >>> 1) <= r) begin
          rr = r - (c >>> 1); cc = 9'sd1;
        end else begin
          rr = r - ab; cc = c - (ab <<< 1);
        end
        if (cc == 9'sd0) begin
          sel_o.j0 = -rr; sel_o.j1 = -rr - 9'sd1;
        end else if (cc == 9'sd1) begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = 9'sd1 - rr; sel_o.j1 = -rr; sel_o.j2 = -rr - 9'sd1;
        end else begin
          sel_o.avg3 = 1'b1;
          sel_o.j0 = cc - 9'sd2; sel_o.j1 = cc - 9'sd1; sel_o.j2 = cc;
        end
      end
      default: sel_o.zero = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/dip_filter.sv =====
`default_nettype none
// Shared averaging unit: AVG2, AVG3, copy of the middle tap, or zero.
module dip_filter (
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  input  wire logic [7:0] c_i,
  input  wire logic       avg3_i,
  input  wire logic       copy_i,
  input  wire logic       zero_i,
  output logic [7:0]      pix_o
);
  logic [9:0] s2, s3;
  always_comb begin
    s2 = {2'b0, a_i} + {2'b0, b_i} + 10'd1;
    s3 = {2'b0, a_i} + {1'b0, b_i, 1'b0} + {2'b0, c_i} + 10'd2;
    if (zero_i)      pix_o = 8'd0;
    else if (copy_i) pix_o = b_i;
    else if (avg3_i) pix_o = s3[9:2];
    else             pix_o = s2[8:1];
  end
endmodule
`default_nettype wire

// ===== rtl/core/directional_intra_predictor_top.sv =====
`default_nettype none
// Loads: no results; the block stays ready.
// Row request: for each pixel, three pipelined edge reads (fetch state) then
// one filter/output step (output state); no new request is accepted until the
// row's last pixel has been registered.
// Output register holds a pixel while stalled; the sequencer waits on it.
// Reset (async, active low): size 4, mode d207; edge stores are not cleared.
module directional_intra_predictor_top import dip_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MaxBlockDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [2:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [6:0] edge_index_i,
  input  wire logic [7:0] sample_i,
  input  wire logic [4:0] row_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      pixel_o,
  output logic [4:0]      column_o,
  output logic            last_o
);
  localparam int unsigned AboveDepth = 2 * MAX_BLOCK + 1;
  localparam int unsigned LeftDepth  = MAX_BLOCK;
  localparam int unsigned EdgeDepth  = AboveDepth + LeftDepth;
  localparam int unsigned EdgeAw     = $clog2(EdgeDepth);
  localparam int unsigned MaxLog2    = $clog2(MAX_BLOCK);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  // unified store: addr = j + LeftDepth (left reversed below the corner)
  logic [7:0] edge_mem [EdgeDepth];
  logic [2:0] lg_q, mode_q;
  logic [1:0] st_q, st_d;
  logic [5:0] col_q, col_d, row_q, row_d;
  logic [6:0] bs_q, bs_d;
  logic [1:0] tap_q, tap_d;
  logic [7:0] ta_q, tb_q, tc_q, rd_q;
  logic [2:0] lgc;
  logic [6:0] bs_w;
  tap_sel_t   sel;
  logic       acc, wr_en;
  logic [EdgeAw-1:0] wr_addr, rd_addr;
  logic signed [8:0] jsel;
  logic [7:0] pix;
  logic       ov_q;
  logic [7:0] pix_q;
  logic [4:0] col_o_q;
  logic       last_q;
  logic       rd_valid_q;

  assign lgc  = (lg_q < 3'd2) ? 3'd2 :
                ({1'b0, lg_q} > 4'(MaxLog2)) ? 3'(MaxLog2) : lg_q;
  assign bs_w = 7'(1) << lgc;

  assign in_stall_o = (st_q != StIdle);
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    if (acc && opcode_i == OpLoadAbove && 32'(edge_index_i) < AboveDepth) begin
      wr_en = 1'b1;
      wr_addr = EdgeAw'(32'(edge_index_i) + LeftDepth);
    end else if (acc && opcode_i == OpLoadLeft && 32'(edge_index_i) < LeftDepth) begin
      wr_en = 1'b1;
      wr_addr = EdgeAw'(LeftDepth - 1 - 32'(edge_index_i));
    end
  end

  dip_tap_gen u_tap (
    .mode_i(mode_q), .bs_i(bs_q), .row_i(row_q), .col_i(col_q), .sel_o(sel)
  );

  always_comb begin
    case (tap_q)
      2'd0:    jsel = sel.j0;
      2'd1:    jsel = sel.j1;
      default: jsel = sel.j2;
    endcase
    rd_addr = EdgeAw'(32'(int'(jsel)) + LeftDepth);
  end

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) edge_mem[wr_addr] <= sample_i;
    rd_q <= edge_mem[rd_addr];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= 3'd2;
      mode_q <= ModeD207;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegBlockLog2) lg_q <= cfg_data_i;
      else mode_q <= cfg_data_i;
    end
  end

  dip_filter u_filt (
    .a_i(ta_q), .b_i(tb_q), .c_i(tc_q), .avg3_i(sel.avg3), .copy_i(sel.copy),
    .zero_i(sel.zero), .pix_o(pix)
  );

  // sequencer: fetch three taps (pipelined read), then emit
  always_comb begin
    st_d = st_q; col_d = col_q; row_d = row_q; bs_d = bs_q; tap_d = tap_q;
    case (st_q)
      StIdle: begin
        if (acc && opcode_i == OpEmitRow) begin
          bs_d = bs_w;
          row_d = 6'({1'b0, row_index_i} & 6'(bs_w - 7'd1));
          col_d = '0;
          tap_d = '0;
          st_d = StFetch;
        end
      end
      StFetch: begin
        if (tap_q == 2'd3) st_d = StOut;
        else tap_d = tap_q + 2'd1;
      end
      StOut: begin
        if (!ov_q || !out_stall_i) begin
          tap_d = '0;
          if (7'(col_q) == bs_q - 7'd1) st_d = StIdle;
          else begin
            col_d = col_q + 6'd1;
            st_d = StFetch;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; col_q <= '0; row_q <= '0; bs_q <= 7'd4; tap_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      st_q <= st_d; col_q <= col_d; row_q <= row_d; bs_q <= bs_d; tap_q <= tap_d;
      rd_valid_q <= (st_q == StFetch) && (tap_q != 2'd3);
    end
  end

  // tap capture: read data arrives in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      case (tap_q)
        2'd1:    ta_q <= rd_q;
        2'd2:    tb_q <= rd_q;
        default: tc_q <= rd_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (st_q == StOut && (!ov_q || !out_stall_i)) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StOut && (!ov_q || !out_stall_i)) begin
      pix_q <= pix;
      col_o_q <= col_q[4:0];
      last_q <= (7'(col_q) == bs_q - 7'd1);
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_o = pix_q;
  assign column_o = col_o_q;
  assign last_o = last_q;
endmodule
`default_nettype wire

// ===== rtl/core/dip_checker.sv =====
`default_nettype none
module dip_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] pixel_o,
  input wire logic [4:0] column_o,
  input wire logic       last_o
);
  logic [4:0] next_col_q;

  // column expected on the next pixel: restarts at 0 after a last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_col_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      next_col_q <= last_o ? 5'd0 : column_o + 5'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o))
    else $error("stalled pixel changed");
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> column_o == next_col_q)
    else $error("column out of sequence");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o || last_o)
    else $error("accepting while row busy");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !in_stall_o |-> last_o)
    else $error("row ended early");
endmodule
bind directional_intra_predictor_top dip_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .pixel_o(pixel_o),
  .column_o(column_o), .last_o(last_o)
);
`default_nettype wire

// ===== tb/sv/directional_intra_predictor_top_tb.sv =====
module directional_intra_predictor_top_tb;
  import dip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [7:0] pixel;
    logic [4:0] column;
    logic       last;
  } pixel_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [2:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i = '0;
  logic [6:0] edge_index_i = '0;
  logic [7:0] sample_i = '0;
  logic [4:0] row_index_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] pixel_o;
  logic [4:0] column_o;
  logic       last_o;

  directional_intra_predictor_top dut (.*);

  // predictor copy of the edge stores and registers
  logic [7:0] above_ref [65];
  logic [7:0] left_ref [32];
  logic [2:0] size_log2_ref = 3'd2;
  logic [2:0] mode_ref = 3'd0;

  pixel_t     pixel_q [$];
  int         err_count = 0;
  int         req_count = 0;
  int         pixel_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         hold_req = 0;
  int         hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int avg2(int a, int b);
    return (a + b + 1) >> 1;
  endfunction

  function automatic int avg3(int a, int b, int c);
    return (a + 2 * b + c + 2) >> 2;
  endfunction

  // unified edge: j >= 0 is above store (0 corner), j < 0 is left[-1-j]
  function automatic int edge_at(int j);
    if (j >= 0) return (j < 65) ? int'(above_ref[7'(j)]) : 0;
    j = -1 - j;
    return (j < 32) ? int'(left_ref[5'(j)]) : 0;
  endfunction

  function automatic int abv(int k);
    return edge_at(k + 1);
  endfunction

  function automatic int lft(int k);
    return edge_at(-1 - k);
  endfunction

  function automatic int diag_pixel(int bs, int r, int c);
    int i;
    int k;
    case (mode_ref)
      ModeD207: begin
        i = r + (c >> 1);
        if ((c & 1) == 0) return (i < bs - 1) ? avg2(lft(i), lft(i + 1)) : lft(bs - 1);
        if (i < bs - 2) return avg3(lft(i), lft(i + 1), lft(i + 2));
        if (i == bs - 2) return avg3(lft(bs - 2), lft(bs - 1), lft(bs - 1));
        return lft(bs - 1);
      end
      ModeD63: begin
        i = r >> 1;
        if (r >= 2 && c >= bs - 1 - i) return abv(bs - 1);
        k = c + i;
        if ((r & 1) == 0) return avg2(abv(k), abv(k + 1));
        return avg3(abv(k), abv(k + 1), abv(k + 2));
      end
      ModeD45: begin
        k = r + c;
        if (k < bs - 1) return avg3(abv(k), abv(k + 1), abv(k + 2));
        return abv(bs - 1);
      end
      ModeD117: begin
        k = ((r >> 1) < c) ? (r >> 1) : c;
        r -= 2 * k;
        c -= k;
        if (r == 0) return avg2(abv(c - 1), abv(c));
        if (r == 1) return (c == 0) ? avg3(lft(0), abv(-1), abv(0))
                                    : avg3(abv(c - 2), abv(c - 1), abv(c));
        if (r == 2) return avg3(abv(-1), lft(0), lft(1));
        return avg3(lft(r - 3), lft(r - 2), lft(r - 1));
      end
      ModeD135: begin
        k = c - r;
        return avg3(edge_at(k - 1), edge_at(k), edge_at(k + 1));
      end
      ModeD153: begin
        while (r >= 1 && c >= 2) begin
          r--;
          c -= 2;
        end
        if (c == 0) return avg2(edge_at(-r), edge_at(-r - 1));
        if (c == 1) return avg3(edge_at(1 - r), edge_at(-r), edge_at(-r - 1));
        return avg3(edge_at(c - 2), edge_at(c - 1), edge_at(c));
      end
      default: return 0;
    endcase
  endfunction

  // apply an accepted request and queue the pixels it produces
  task automatic predict_request();
    int bs;
    int r;
    pixel_t px;
    case (opcode_i)
      OpLoadAbove: if (edge_index_i < 65) above_ref[edge_index_i] = sample_i;
      OpLoadLeft:  if (edge_index_i < 32) left_ref[edge_index_i[4:0]] = sample_i;
      OpEmitRow: begin
        bs = (size_log2_ref <= 2) ? 4 : (size_log2_ref >= 5) ? 32 : (1 << size_log2_ref);
        r = row_index_i & (bs - 1);
        for (int c = 0; c < bs; c++) begin
          px.pixel = 8'(diag_pixel(bs, r, c));
          px.column = 5'(c);
          px.last = (c == bs - 1);
          pixel_q.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  // input side monitor: register writes and accepted requests
  always @(posedge clk_i) begin
    if (cfg_we_i) begin
      if (cfg_idx_i == RegBlockLog2) size_log2_ref = cfg_data_i;
      else mode_ref = cfg_data_i;
    end
    if (in_valid_i && !in_stall_o) begin
      req_count++;
      predict_request();
    end
  end

  // output checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      pixel_count++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel %0d at column %0d", pixel_o, column_o);
        err_count++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_o !== want.pixel) begin
          $error("pixel: expected %0d, got %0d", want.pixel, pixel_o);
          err_count++;
        end
        if (column_o !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, column_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_count++;
        end
      end
    end
  end

  // receiver stall: random, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // all stimulus tasks start and end on a falling edge
  task automatic send_request(logic [1:0] op, logic [6:0] idx, logic [7:0] smp,
                              logic [4:0] row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    edge_index_i <= idx;
    sample_i <= smp;
    row_index_i <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int n = 0;
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) begin
      @(negedge clk_i);
      n++;
      if (n > 400_000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [2:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // 4x4 edges at the sample extremes, ignored loads, then one row per mode value
  task automatic test_directed();
    write_reg(RegBlockLog2, 3'd0);
    for (int j = 0; j < 9; j++)
      send_request(OpLoadAbove, 7'(j), (j & 1) ? 8'd0 : 8'd255, 5'd0);
    for (int j = 0; j < 4; j++)
      send_request(OpLoadLeft, 7'(j), (j & 1) ? 8'd255 : 8'd0, 5'd0);
    send_request(OpLoadAbove, 7'd127, 8'd17, 5'd0);
    send_request(OpLoadLeft, 7'd32, 8'd17, 5'd0);
    send_request(OpUnused, 7'd0, 8'd17, 5'd0);
    for (int m = 0; m < 8; m++) begin
      write_reg(RegPredMode, 3'(m));
      send_request(OpEmitRow, 7'd0, 8'd0, (m & 1) ? 5'd31 : m[4:0]);
    end
  endtask

  // fill both stores completely so no later read hits an unwritten entry
  task automatic test_full_edges();
    for (int j = 0; j < 65; j++)
      send_request(OpLoadAbove, 7'(j), 8'($urandom_range(255)), 5'd0);
    for (int j = 0; j < 32; j++)
      send_request(OpLoadLeft, 7'(j), 8'($urandom_range(255)), 5'd0);
  endtask

  // random phases: mostly row requests, some reloads and noise
  task automatic test_random(int phases, int per_phase);
    int sel;
    for (int p = 0; p < phases; p++) begin
      write_reg(RegBlockLog2, (p == 0) ? 3'd7 : 3'($urandom_range(7)));
      write_reg(RegPredMode, (p == 0) ? ModeD153 : 3'($urandom_range(7)));
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(9);
        if (sel < 6)
          send_request(OpEmitRow, 7'($urandom), 8'($urandom), 5'($urandom_range(31)));
        else if (sel < 8)
          send_request(OpLoadAbove, 7'($urandom_range(127)), 8'($urandom), 5'($urandom));
        else if (sel < 9)
          send_request(OpLoadLeft, 7'($urandom_range(127)), 8'($urandom), 5'($urandom));
        else
          send_request(OpUnused, 7'($urandom), 8'($urandom), 5'($urandom));
      end
    end
  endtask

  // long receiver hold-off while the sender keeps offering rows
  task automatic test_backpressure();
    write_reg(RegBlockLog2, 3'd5);
    write_reg(RegPredMode, ModeD45);
    hold_req = 400;
    for (int i = 0; i < 8; i++) send_request(OpEmitRow, 7'd0, 8'd0, 5'(i));
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_edges();
    tx_idle_pct = 15;
    rx_idle_pct = 62;
    test_random(4, 25);
    tx_idle_pct = 62;
    rx_idle_pct = 15;
    test_random(4, 25);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(4, 25);
    test_backpressure();
    wait_drained();
    $display("covered %0d requests across all sizes and modes, %0d pixels checked",
             req_count, pixel_count);
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
